>>> rtl/core/crast_pkg.sv
// Shared codes for the circle rasterizer: action kinds and octant order.
// No dependencies; used by crast_front, crast_back and circle_rasterizer.
package crast_pkg;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   localparam int OCT_BITS = 3;

   typedef enum logic [OCT_BITS-1:0] {
      OCT_PX_PY = 3'd0,
      OCT_PY_PX = 3'd1,
      OCT_NX_PY = 3'd2,
      OCT_NY_PX = 3'd3,
      OCT_NX_NY = 3'd4,
      OCT_NY_NX = 3'd5,
      OCT_PX_NY = 3'd6,
      OCT_PY_NX = 3'd7
   } octant_type;

   localparam octant_type OCT_FIRST = OCT_PX_PY;
   localparam octant_type OCT_LAST  = OCT_PY_NX;

endpackage

>>> rtl/core/crast_front.sv
// Front end: accepts start/step words, runs the midpoint recurrence and queues jobs.
// Depends on crast_pkg; feeds crast_queue.
module crast_front #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 12
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0]   req_tdata,
   input  logic                                            req_tuser,
   output logic                                            job_valid,
   input  logic                                            job_ready,
   output logic [2*COORD_BITS+2*(RADIUS_BITS+2):0]         job_data
);

   localparam int XY_BITS  = RADIUS_BITS + 2;
   localparam int DEC_BITS = RADIUS_BITS + 5;

   logic signed [XY_BITS-1:0]    offset_x_ff, offset_x_in;
   logic signed [XY_BITS-1:0]    offset_y_ff, offset_y_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic signed [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic signed [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic                         active_ff, active_in;

   logic                         is_start;
   logic                         accept;
   logic                         emit;
   logic [RADIUS_BITS-1:0]       radius;
   logic signed [XY_BITS-1:0]    cur_x, cur_y;
   logic signed [DEC_BITS-1:0]   cur_d;
   logic signed [COORD_BITS-1:0] cur_cx, cur_cy;
   logic signed [XY_BITS:0]      diff_xy;
   logic                         done;

   assign req_tready = job_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = (req_tuser == crast_pkg::ACTION_START);
   assign radius     = req_tdata[2*COORD_BITS +: RADIUS_BITS];
   assign emit       = accept && (is_start || active_ff);

   always_comb begin
      if (is_start) begin
         cur_cx = req_tdata[COORD_BITS-1:0];
         cur_cy = req_tdata[2*COORD_BITS-1:COORD_BITS];
         cur_x  = '0;
         cur_y  = XY_BITS'(radius);
         cur_d  = DEC_BITS'(3) - (DEC_BITS'(radius) <<< 1);
      end else begin
         cur_cx = center_x_ff;
         cur_cy = center_y_ff;
         cur_x  = offset_x_ff;
         cur_y  = offset_y_ff;
         cur_d  = decision_ff;
      end

      diff_xy = (XY_BITS+1)'(cur_x) - (XY_BITS+1)'(cur_y);
      if (cur_d < 0) begin
         decision_in = cur_d + (DEC_BITS'(cur_x) <<< 2) + DEC_BITS'(6);
         offset_y_in = cur_y;
      end else begin
         decision_in = cur_d + (DEC_BITS'(diff_xy) <<< 2) + DEC_BITS'(10);
         offset_y_in = cur_y - XY_BITS'(1);
      end
      offset_x_in = cur_x + XY_BITS'(1);
      done        = (offset_x_in > offset_y_in);
      center_x_in = cur_cx;
      center_y_in = cur_cy;
      active_in   = !done;
   end

   assign job_valid = emit;
   assign job_data  = {done, cur_y, cur_x, cur_cy, cur_cx};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (emit) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

endmodule

>>> rtl/core/crast_queue.sv
// Two-entry job queue between the front end and the point emitter.
// No dependencies.
module crast_queue #(
   parameter int WIDTH = 59
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/crast_back.sv
// Back end: walks the eight octants of each queued job, one point word per cycle unless rsp_tready stalls it.
// Depends on crast_pkg; drains crast_queue.
module crast_back #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 12
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        job_valid,
   output logic                                        job_ready,
   input  logic [2*COORD_BITS+2*(RADIUS_BITS+2):0]     job_data,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((2*(COORD_BITS+1)+crast_pkg::OCT_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                        rsp_tlast,
   output logic                                        rsp_tuser
);

   localparam int XY_BITS  = RADIUS_BITS + 2;
   localparam int PT_BITS  = COORD_BITS + 1;
   localparam int SUM_BITS = (PT_BITS > XY_BITS) ? PT_BITS : XY_BITS;
   localparam int JOB_BITS = 2*COORD_BITS + 2*XY_BITS + 1;
   localparam int RAW_BITS = 2*PT_BITS + crast_pkg::OCT_BITS;
   localparam int OUT_BITS = ((RAW_BITS + 7) / 8) * 8;

   logic                    busy_ff, busy_in;
   logic [JOB_BITS-1:0]     job_ff;
   crast_pkg::octant_type   oct_ff, oct_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [PT_BITS-1:0] pt_x_ff, pt_x_in;
   logic signed [PT_BITS-1:0] pt_y_ff, pt_y_in;
   crast_pkg::octant_type   out_oct_ff;
   logic                    out_last_ff, out_last_in;
   logic                    out_done_ff, out_done_in;

   logic                    load;
   logic                    take;
   logic                    at_last;
   logic signed [COORD_BITS-1:0] cx, cy;
   logic signed [XY_BITS-1:0]    jx, jy, ax, ay;
   logic                    job_done;
   logic                    neg_x, neg_y;
   logic signed [SUM_BITS-1:0] sum_x, sum_y;

   assign cx       = job_ff[COORD_BITS-1:0];
   assign cy       = job_ff[2*COORD_BITS-1:COORD_BITS];
   assign jx       = job_ff[2*COORD_BITS +: XY_BITS];
   assign jy       = job_ff[2*COORD_BITS+XY_BITS +: XY_BITS];
   assign job_done = job_ff[JOB_BITS-1];

   assign load      = busy_ff && (!out_valid_ff || rsp_tready);
   assign at_last   = (oct_ff == crast_pkg::OCT_LAST);
   assign take      = job_valid && (!busy_ff || (load && at_last));
   assign job_ready = take;

   always_comb begin
      ax    = oct_ff[0] ? jy : jx;
      ay    = oct_ff[0] ? jx : jy;
      neg_y = oct_ff[2];
      neg_x = oct_ff[2] ^ oct_ff[1];
      sum_x = neg_x ? SUM_BITS'(cx) - SUM_BITS'(ax) : SUM_BITS'(cx) + SUM_BITS'(ax);
      sum_y = neg_y ? SUM_BITS'(cy) - SUM_BITS'(ay) : SUM_BITS'(cy) + SUM_BITS'(ay);
      pt_x_in     = sum_x[PT_BITS-1:0];
      pt_y_in     = sum_y[PT_BITS-1:0];
      out_last_in = at_last;
      out_done_in = at_last && job_done;

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      busy_in = busy_ff;
      oct_in  = oct_ff;
      if (take) begin
         busy_in = 1'b1;
         oct_in  = crast_pkg::OCT_FIRST;
      end else if (load) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            oct_in = crast_pkg::octant_type'(oct_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         oct_ff       <= crast_pkg::OCT_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         oct_ff       <= oct_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_data;
      end
      if (load) begin
         pt_x_ff     <= pt_x_in;
         pt_y_ff     <= pt_y_in;
         out_oct_ff  <= oct_ff;
         out_last_ff <= out_last_in;
         out_done_ff <= out_done_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_BITS'({out_oct_ff, pt_y_ff, pt_x_ff});
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

>>> rtl/core/circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: front end, job queue, point emitter.
// Depends on crast_pkg, crast_front, crast_queue and crast_back.
//
//   channel | dir | payload
//   req_    | in  | tdata: center_x, center_y, radius; tuser: action (0 start, 1 step)
//   rsp_    | out | tdata: point_x, point_y, octant; tlast: last_of_step;
//           |     | tuser: circle_done
//
// A start or a step with a circle running yields eight point words, one per cycle
// while rsp_tready is high, so the result port paces such items.
// A step with no circle running is absorbed once the queue has room and yields nothing.
// The two-entry job queue lets the front end take items while points drain.
// Reset (synchronous, active high) empties the queue and leaves no circle running.
module circle_rasterizer #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 12
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // center_x, center_y, radius, zero fill
   input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0]  req_tdata,
   // action
   input  logic                                           req_tuser,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // point_x, point_y, octant, zero fill
   output logic [((2*(COORD_BITS+1)+crast_pkg::OCT_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                           rsp_tlast,
   // circle_done
   output logic                                           rsp_tuser
);

   localparam int JOB_BITS = 2*COORD_BITS + 2*(RADIUS_BITS+2) + 1;

   logic                push_valid, push_ready;
   logic [JOB_BITS-1:0] push_data;
   logic                pop_valid, pop_ready;
   logic [JOB_BITS-1:0] pop_data;

   crast_front #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (push_valid),
      .job_ready  (push_ready),
      .job_data   (push_data)
   );

   crast_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   crast_back #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_rasterizer: directed table, then random circles.
// Depends on crast_pkg and the circle_rasterizer RTL; points are checked by an in-bench tracer.
module testbench;

   localparam int COORD_W       = 12;
   localparam int RADIUS_W      = 10;
   localparam int REQ_W         = ((2*COORD_W+RADIUS_W+7)/8)*8;
   localparam int RSP_W         = ((2*(COORD_W+1)+crast_pkg::OCT_BITS+7)/8)*8;
   localparam int DIRECTED_ROWS = 22;
   localparam int TOTAL_ITEMS   = 230;
   localparam int HOLD_CYCLES   = 200;
   localparam int WATCHDOG      = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef enum {EXP_MODEL, EXP_NONE, EXP_CENTER} exp_src_type;

   typedef struct {
      logic signed [12:0]    x;
      logic signed [12:0]    y;
      crast_pkg::octant_type oct;
      logic                  last;
      logic                  done;
   } point_word_type;

   typedef struct {
      logic        act;
      logic [11:0] cx;
      logic [11:0] cy;
      logic [9:0]  r;
      exp_src_type src;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // center_x, center_y, radius, zero fill
   logic             req_tuser;   // action
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // point_x, point_y, octant, zero fill
   logic             rsp_tlast;
   logic             rsp_tuser;   // circle_done

   exp_src_type    word_src;
   bit             hold_req;
   bit             no_idle;
   point_word_type pending_points[$];
   int             errors;
   int             idle_cycles;
   int             starts_taken;
   int             steps_taken;
   int             points_checked;
   int             circles_done;

   int trace_x, trace_y, trace_d, trace_cx, trace_cy;
   bit trace_on;

   plan_row_type directed[DIRECTED_ROWS] = '{
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_NONE},
      '{crast_pkg::ACTION_START, 12'h000, 12'h000, 10'd0,    EXP_CENTER},
      '{crast_pkg::ACTION_STEP,  12'hABC, 12'h543, 10'h3FF,  EXP_NONE},
      '{crast_pkg::ACTION_START, 12'h7FF, 12'h800, 10'd0,    EXP_CENTER},
      '{crast_pkg::ACTION_START, 12'h800, 12'h7FF, 10'd0,    EXP_CENTER},
      '{crast_pkg::ACTION_START, 12'h800, 12'h7FF, 10'd1023, EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h555, 12'hAAA, 10'h155,  EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'hAAA, 12'h555, 10'h2AA,  EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'hFFF, 12'hFFF, 10'h3FF,  EXP_MODEL},
      '{crast_pkg::ACTION_START, 12'd100, 12'hF9C, 10'd5,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_START, 12'h7FF, 12'h7FF, 10'd1023, EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_START, 12'h800, 12'h800, 10'd1023, EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_START, 12'h123, 12'h456, 10'd1,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL},
      '{crast_pkg::ACTION_STEP,  12'h000, 12'h000, 10'd0,    EXP_MODEL}
   };

   circle_rasterizer #(
      .RADIUS_BITS(RADIUS_W),
      .COORD_BITS (COORD_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Walk the midpoint tracer one item; queue the eight points when asked.
   function automatic void trace_item(logic act, logic [11:0] cx, logic [11:0] cy,
                                      logic [9:0] r, bit emit);
      int             px[8];
      int             py[8];
      int             x, y;
      bit             fin;
      point_word_type w;
      if (act == crast_pkg::ACTION_START) begin
         trace_cx = int'($signed(cx));
         trace_cy = int'($signed(cy));
         trace_x  = 0;
         trace_y  = int'(r);
         trace_d  = 3 - 2 * trace_y;
         trace_on = 1'b1;
      end else if (!trace_on) begin
         return;
      end
      x  = trace_x;
      y  = trace_y;
      px = '{trace_cx + x, trace_cx + y, trace_cx - x, trace_cx - y,
             trace_cx - x, trace_cx - y, trace_cx + x, trace_cx + y};
      py = '{trace_cy + y, trace_cy + x, trace_cy + y, trace_cy + x,
             trace_cy - y, trace_cy - x, trace_cy - y, trace_cy - x};
      if (trace_d < 0) begin
         trace_d += 4 * x + 6;
      end else begin
         trace_d += 4 * (x - y) + 10;
         trace_y--;
      end
      trace_x++;
      fin = trace_x > trace_y;
      if (fin) trace_on = 1'b0;
      if (emit) begin
         for (int k = 0; k < 8; k++) begin
            w.x    = 13'(px[k]);
            w.y    = 13'(py[k]);
            w.oct  = crast_pkg::octant_type'(k);
            w.last = (k == 7);
            w.done = (k == 7) && fin;
            pending_points.push_back(w);
         end
      end
   endfunction

   // Log accepted words, check points, and watch for a hung handshake.
   always @(posedge clock) begin
      point_word_type        w;
      logic signed [12:0]    got_x, got_y;
      crast_pkg::octant_type got_oct;
      bit                    moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            if (req_tuser == crast_pkg::ACTION_START) starts_taken++;
            else steps_taken++;
            unique case (word_src)
               EXP_NONE: trace_item(req_tuser, req_tdata[11:0], req_tdata[23:12],
                                    req_tdata[33:24], 1'b0);
               EXP_CENTER: begin
                  trace_item(req_tuser, req_tdata[11:0], req_tdata[23:12],
                             req_tdata[33:24], 1'b0);
                  for (int k = 0; k < 8; k++) begin
                     w.x    = 13'($signed(req_tdata[11:0]));
                     w.y    = 13'($signed(req_tdata[23:12]));
                     w.oct  = crast_pkg::octant_type'(k);
                     w.last = (k == 7);
                     w.done = (k == 7);
                     pending_points.push_back(w);
                  end
               end
               default: trace_item(req_tuser, req_tdata[11:0], req_tdata[23:12],
                                   req_tdata[33:24], 1'b1);
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got_x   = rsp_tdata[12:0];
            got_y   = rsp_tdata[25:13];
            got_oct = crast_pkg::octant_type'(rsp_tdata[28:26]);
            if (rsp_tuser) circles_done++;
            if (pending_points.size() == 0) begin
               $error("unexpected point word: x %0d y %0d octant %0d", got_x, got_y, got_oct);
               errors++;
            end else begin
               w = pending_points.pop_front();
               points_checked++;
               if (got_x !== w.x) begin
                  $error("point_x: expected %0d, got %0d", w.x, got_x);
                  errors++;
               end
               if (got_y !== w.y) begin
                  $error("point_y: expected %0d, got %0d", w.y, got_y);
                  errors++;
               end
               if (got_oct !== w.oct) begin
                  $error("octant: expected %0d, got %0d", w.oct, got_oct);
                  errors++;
               end
               if (rsp_tlast !== w.last) begin
                  $error("last_of_step: expected %0d, got %0d", w.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser !== w.done) begin
                  $error("circle_done: expected %0d, got %0d", w.done, rsp_tuser);
                  errors++;
               end
            end
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side: random back-pressure, plus one long hold on request.
   initial begin : rsp_side
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            n = no_idle ? 0 : pick_gap();
            if (n == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (n - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic send_word(logic act, logic [11:0] cx, logic [11:0] cy, logic [9:0] r,
                            exp_src_type src);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_W-34){1'b0}}, r, cy, cx};
      word_src   <= src;
      do @(posedge clock); while (!req_tready);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_points();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
   endtask

   initial begin : req_side
      int          made;
      int          span;
      logic [9:0]  r;
      logic [11:0] cx, cy;
      bit          cut;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = crast_pkg::ACTION_STEP;
      word_src   = EXP_MODEL;
      hold_req   = 1'b0;
      no_idle    = 1'b0;
      made       = DIRECTED_ROWS;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_word(directed[i].act, directed[i].cx, directed[i].cy, directed[i].r,
                   directed[i].src);

      for (int circle = 0; made < TOTAL_ITEMS; circle++) begin
         if (circle == 3) hold_req = 1'b1;
         if (circle == 6) drain_points();
         no_idle = (circle >= 9 && circle < 13);
         case ($urandom_range(0, 19))
            0:       r = 10'($urandom_range(512, 1023));
            1, 2:    r = 10'($urandom_range(25, 100));
            default: r = 10'($urandom_range(0, 24));
         endcase
         cx  = 12'($urandom);
         cy  = 12'($urandom);
         cut = (r > 100) || ($urandom_range(0, 99) < 15);
         span = int'(r) * 3 / 4 + 2;
         if (cut) span = $urandom_range(1, (span < 30) ? span : 30);
         send_word(crast_pkg::ACTION_START, cx, cy, r, EXP_MODEL);
         made++;
         for (int s = 0; s < span; s++) begin
            send_word(crast_pkg::ACTION_STEP, 12'($urandom), 12'($urandom),
                      10'($urandom), EXP_MODEL);
            made++;
         end
      end
      no_idle = 1'b0;

      drain_points();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d starts and %0d steps; %0d points checked, %0d circles finished",
               starts_taken, steps_taken, points_checked, circles_done);
      $display("%0d mismatches or stray points", errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
